### rtl/rfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfd_pkg
// Shared types, sizes and codes of the run-length frame decoder.
// ----------------------------------------------------------------------------
package rfd_pkg;

  // Frame memory geometry
  localparam int FrameCapacity = 1024;
  localparam int MemAddrW      = $clog2(FrameCapacity);
  localparam int SizeW         = $clog2(FrameCapacity + 1);

  // Command queue between front and back
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  // Configuration port
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 11;
  localparam logic [CfgIdxW-1:0]  RegFrameSize = 1'd0;
  localparam logic [CfgIdxW-1:0]  RegXorMode   = 1'd1;
  localparam logic [CfgDataW-1:0] FrameSizeReset = 11'd1024;

  // Command codes
  localparam logic [2:0] FuncStartClear = 3'd0;
  localparam logic [2:0] FuncStartKeep  = 3'd1;
  localparam logic [2:0] FuncRun        = 3'd2;
  localparam logic [2:0] FuncEnd        = 3'd3;
  localparam logic [2:0] FuncRead       = 3'd4;

  // Status codes
  localparam logic [2:0] StatusOk       = 3'd0;
  localparam logic [2:0] StatusRejected = 3'd1;
  localparam logic [2:0] StatusIgnored  = 3'd2;
  localparam logic [2:0] StatusComplete = 3'd3;
  localparam logic [2:0] StatusFailed   = 3'd4;

  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_KEEP,
    OP_RUN,
    OP_END,
    OP_READ,
    OP_NONE
  } op_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  count;
    logic [7:0]  value;
    logic [9:0]  address;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  read_data;
    logic [10:0] fill_level;
  } res_item_t;

  typedef struct packed {
    op_e         op;
    logic [7:0]  count;
    logic [7:0]  value;
    logic [9:0]  address;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef struct packed {
    logic [SizeW-1:0] size;
    logic             xor_en;
  } cfg_t;

endpackage

### rtl/rfd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfd_front
// Accepts commands, classifies the function code and queues the item.
// ----------------------------------------------------------------------------
module rfd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  rfd_pkg::in_item_t  in_i,
  output logic               busy_o,
  output rfd_pkg::q_head_t   head_o,
  input  logic               pop_i
);

  rfd_pkg::cmd_t                q_mem_q [rfd_pkg::QueueDepth];
  logic [rfd_pkg::QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [rfd_pkg::QueuePtrW:0]   fill_q;
  rfd_pkg::cmd_t                cmd;
  logic                         full, push, pop;

  // Classify the function code
  always_comb begin
    cmd.count   = in_i.count;
    cmd.value   = in_i.value;
    cmd.address = in_i.address;
    case (in_i.func)
      rfd_pkg::FuncStartClear: cmd.op = rfd_pkg::OP_CLEAR;
      rfd_pkg::FuncStartKeep:  cmd.op = rfd_pkg::OP_KEEP;
      rfd_pkg::FuncRun:        cmd.op = rfd_pkg::OP_RUN;
      rfd_pkg::FuncEnd:        cmd.op = rfd_pkg::OP_END;
      rfd_pkg::FuncRead:       cmd.op = rfd_pkg::OP_READ;
      default:                 cmd.op = rfd_pkg::OP_NONE;
    endcase
  end

  assign full   = (fill_q == (rfd_pkg::QueuePtrW + 1)'(rfd_pkg::QueueDepth));
  assign busy_o = full;
  assign push   = start_i && !full;
  assign pop    = pop_i && head_o.valid;

  assign head_o.valid = (fill_q != '0);
  assign head_o.cmd   = q_mem_q[rd_ptr_q];

  // Store pushed items
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

### rtl/rfd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfd_back
// Executes queued commands on the frame memory and produces one result each.
// ----------------------------------------------------------------------------
module rfd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rfd_pkg::cfg_t       cfg_i,
  input  rfd_pkg::q_head_t    head_i,
  output logic                pop_o,
  output logic                done_o,
  output rfd_pkg::res_item_t  res_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLEAR,
    S_RUN,
    S_READ
  } state_e;

  state_e                          state_q;
  logic [rfd_pkg::MemAddrW-1:0]    addr_q, pend_addr_q;
  logic [rfd_pkg::SizeW-1:0]       cnt_q, wp_q;
  logic [7:0]                      value_q;
  logic                            pend_q, err_q, rd_zero_q, done_q;
  rfd_pkg::res_item_t              res_q;

  logic [7:0]                      mem_q [rfd_pkg::FrameCapacity];
  logic [7:0]                      mem_rdata_q;
  logic                            mem_we, mem_re;
  logic [rfd_pkg::MemAddrW-1:0]    mem_waddr, mem_raddr;
  logic [7:0]                      mem_wdata;

  logic [rfd_pkg::SizeW-1:0]       room;
  logic                            run_bad;

  // Reject a zero-length run or one longer than the bytes left in the frame
  assign room    = cfg_i.size - wp_q;
  assign run_bad = (head_i.cmd.count == 8'd0) ||
                   ({{rfd_pkg::SizeW{1'b0}}, head_i.cmd.count} > {8'd0, room});

  assign pop_o  = (state_q == S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  // Drive memory ports from the current state
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = pend_addr_q;
    mem_raddr = addr_q;
    mem_wdata = value_q;
    case (state_q)
      S_IDLE: begin
        if (head_i.valid && head_i.cmd.op == rfd_pkg::OP_READ) begin
          mem_re    = 1'b1;
          mem_raddr = rfd_pkg::MemAddrW'(head_i.cmd.address);
        end
      end
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_q;
        mem_wdata = 8'd0;
      end
      S_RUN: begin
        mem_re = (cnt_q != '0) && cfg_i.xor_en;
        mem_we = pend_q;
        if (cfg_i.xor_en) begin
          mem_wdata = mem_rdata_q ^ value_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Frame memory with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

  // Sequence commands and register results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      addr_q      <= '0;
      pend_addr_q <= '0;
      cnt_q       <= '0;
      wp_q        <= '0;
      value_q     <= '0;
      pend_q      <= 1'b0;
      err_q       <= 1'b0;
      rd_zero_q   <= 1'b0;
      done_q      <= 1'b0;
      res_q       <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (head_i.valid) begin
            res_q.read_data  <= 8'd0;
            res_q.fill_level <= 11'(wp_q);
            case (head_i.cmd.op)
              rfd_pkg::OP_CLEAR: begin
                wp_q    <= '0;
                err_q   <= 1'b0;
                addr_q  <= '0;
                cnt_q   <= cfg_i.size;
                state_q <= S_CLEAR;
              end
              rfd_pkg::OP_KEEP: begin
                wp_q             <= '0;
                err_q            <= 1'b0;
                done_q           <= 1'b1;
                res_q.status     <= rfd_pkg::StatusOk;
                res_q.fill_level <= 11'd0;
              end
              rfd_pkg::OP_RUN: begin
                if (err_q || wp_q >= cfg_i.size) begin
                  done_q       <= 1'b1;
                  res_q.status <= rfd_pkg::StatusIgnored;
                end else if (run_bad) begin
                  err_q        <= 1'b1;
                  done_q       <= 1'b1;
                  res_q.status <= rfd_pkg::StatusRejected;
                end else begin
                  addr_q  <= rfd_pkg::MemAddrW'(wp_q);
                  cnt_q   <= rfd_pkg::SizeW'(head_i.cmd.count);
                  value_q <= head_i.cmd.value;
                  wp_q    <= wp_q + rfd_pkg::SizeW'(head_i.cmd.count);
                  pend_q  <= 1'b0;
                  state_q <= S_RUN;
                end
              end
              rfd_pkg::OP_END: begin
                done_q <= 1'b1;
                if (!err_q && wp_q == cfg_i.size) begin
                  res_q.status <= rfd_pkg::StatusComplete;
                end else begin
                  res_q.status <= rfd_pkg::StatusFailed;
                end
              end
              rfd_pkg::OP_READ: begin
                rd_zero_q <= (32'(head_i.cmd.address) >= 32'(rfd_pkg::FrameCapacity));
                state_q   <= S_READ;
              end
              default: begin
                done_q       <= 1'b1;
                res_q.status <= rfd_pkg::StatusIgnored;
              end
            endcase
          end
        end
        // Zero the frame, one byte per cycle
        S_CLEAR: begin
          addr_q <= addr_q + 1'b1;
          cnt_q  <= cnt_q - 1'b1;
          if (cnt_q == rfd_pkg::SizeW'(1)) begin
            done_q           <= 1'b1;
            res_q.status     <= rfd_pkg::StatusOk;
            res_q.fill_level <= 11'd0;
            state_q          <= S_IDLE;
          end
        end
        // Issue one byte per cycle and write it back in the following cycle
        S_RUN: begin
          if (cnt_q != '0) begin
            addr_q      <= addr_q + 1'b1;
            cnt_q       <= cnt_q - 1'b1;
            pend_q      <= 1'b1;
            pend_addr_q <= addr_q;
          end else begin
            pend_q <= 1'b0;
            if (pend_q) begin
              done_q           <= 1'b1;
              res_q.status     <= rfd_pkg::StatusOk;
              res_q.fill_level <= 11'(wp_q);
              state_q          <= S_IDLE;
            end
          end
        end
        // Return the byte read in the dispatch cycle
        S_READ: begin
          done_q           <= 1'b1;
          res_q.status     <= rfd_pkg::StatusOk;
          res_q.read_data  <= rd_zero_q ? 8'd0 : mem_rdata_q;
          res_q.fill_level <= 11'(wp_q);
          state_q          <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/rle_frame_decoder_with_xor_delta.sv
`timescale 1ns / 1ps
// Timing: the back end executes one item at a time and strobes done_o with its result;
// start-keep, end, rejected and ignored items finish in IDLE, a read goes through READ,
// and runs and start-clear walk their bytes through the single frame memory port
// (one byte per cycle); a 2-entry queue absorbs bursts.
// Reset: queue empty, fill level and error cleared, frame size 1024, plain mode;
// frame memory contents are undefined until written. Results cannot be stalled.
// ----------------------------------------------------------------------------
// rle_frame_decoder_with_xor_delta
// Run-length frame decoder with XOR delta: config registers, front and back.
// ----------------------------------------------------------------------------
module rle_frame_decoder_with_xor_delta (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  input  rfd_pkg::in_item_t                 in_i,
  output logic                              busy,
  output logic                              done_o,
  output rfd_pkg::res_item_t                res_o,
  input  logic                              cfg_we_i,
  input  logic [rfd_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [rfd_pkg::CfgDataW-1:0]      cfg_wdata_i
);

  logic [rfd_pkg::CfgDataW-1:0] frame_size_q;
  logic                         xor_en_q;
  rfd_pkg::cfg_t                cfg;
  rfd_pkg::q_head_t             head;
  logic                         pop;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_size_q <= rfd_pkg::FrameSizeReset;
      xor_en_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rfd_pkg::RegFrameSize: frame_size_q <= cfg_wdata_i;
        rfd_pkg::RegXorMode:   xor_en_q     <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  // Limit the frame size to 1..capacity
  always_comb begin
    cfg.xor_en = xor_en_q;
    if (frame_size_q == '0) begin
      cfg.size = rfd_pkg::SizeW'(1);
    end else if (32'(frame_size_q) > 32'(rfd_pkg::FrameCapacity)) begin
      cfg.size = rfd_pkg::SizeW'(rfd_pkg::FrameCapacity);
    end else begin
      cfg.size = rfd_pkg::SizeW'(frame_size_q);
    end
  end

  rfd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .in_i   (in_i),
    .busy_o (busy),
    .head_o (head),
    .pop_i  (pop)
  );

  rfd_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .head_i (head),
    .pop_o  (pop),
    .done_o (done_o),
    .res_o  (res_o)
  );

endmodule
